// File: design/rfme_pkg.sv
// Shared types and constants for the register-file math execute block.
// Holds the transaction layouts, operation codes and the divider handshake.
// No dependencies.
`default_nettype none

package rfme_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 4;
  localparam int IMM_W     = 16;
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;

  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_MULU = 4'd3,
    CMD_MULS = 4'd4,
    CMD_DIVU = 4'd5,
    CMD_DIVS = 4'd6,
    CMD_REMU = 4'd7,
    CMD_REMS = 4'd8,
    CMD_AND  = 4'd9,
    CMD_OR   = 4'd10,
    CMD_XOR  = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_REG_REG = 2'b00,
    MODE_REG_IMM = 2'b01,
    MODE_IMM_REG = 2'b10,
    MODE_IMM_IMM = 2'b11
  } mode_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: design/rfme_div.sv
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on rfme_pkg for the request and response structs.
`default_nettype none

module rfme_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rfme_pkg::div_req_t req,
  output rfme_pkg::div_rsp_t      rsp
);
  import rfme_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   shifted;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {rem, quo[DATA_W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        quo   <= req.dividend;
        dsr   <= req.divisor;
      end else if (busy) begin
        if (!trial[DATA_W]) begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// File: design/register_file_math_execute.sv
// Top level of the register-file math execute block: FSM, register file and ALU.
// Depends on rfme_pkg and instantiates rfme_div for divide and remainder.
//
// Usage:
//   Input channel s_*: one transaction carries one decoded instruction. It is
//   accepted when s_tvalid and s_tready are both high. s_tready is high only
//   while the block is idle, so one instruction is in flight at a time.
//   Output channel m_*: one transaction per instruction, held in an output
//   register until m_tready is high. While it waits, the block still takes
//   and executes the next instruction; it only stalls in its final step if
//   the previous result has not yet been taken.
//   Timing: an instruction passes through the operand, calculate and finish
//   steps from acceptance to readiness for the next one; divide and remainder
//   with a non-zero divisor also wait in a divide step while the iterative
//   divider retires one quotient bit per cycle. The result appears on m_*
//   in the same cycle that s_tready rises again.
//   The register file sits in a synchronous memory with registered reads;
//   per-entry valid bits make unwritten registers read as zero.
//   Reset (rst, synchronous): valid bits cleared, so all registers read as
//   zero; FSM to idle; output channel emptied.
`default_nettype none

module register_file_math_execute #(
  parameter int REG_COUNT = 16,
  parameter int IMM_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output      logic                           s_tready,
  // [3:0] command, [5:4] operand_mode, [9:6] dest_index, [13:10] src_a_index,
  // [17:14] src_b_index, [33:18] imm_first, [49:34] imm_second, rest zero
  input  wire logic [rfme_pkg::S_TDATA_W-1:0] s_tdata,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  // [3:0] written_index, [35:4] written_value, rest zero
  output      logic [rfme_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] wrote, [1] divide_by_zero
  output      logic [rfme_pkg::M_TUSER_W-1:0] m_tuser
);
  import rfme_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [DATA_W-1:0] IMM_MASK =
    (IMM_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << IMM_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPER,
    ST_CALC,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t            state;

  // latched instruction
  logic [IDX_W-1:0]  cmd;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  dest;
  logic [IMM_W-1:0]  imm1;
  logic [IMM_W-1:0]  imm2;

  // register file and its read side
  logic [DATA_W-1:0]    regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_valid;
  logic [DATA_W-1:0]    rd_a;
  logic [DATA_W-1:0]    rd_b;
  logic                 rd_a_ok;
  logic                 rd_b_ok;

  // operands and result
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] res;
  logic              res_ok;
  logic              dz;

  logic              accept;
  logic              out_free;
  logic              wr_en;
  logic              dest_ok;
  logic [IDX_W-1:0]  s_src_a;
  logic [IDX_W-1:0]  s_src_b;
  logic              src_a_ok;
  logic              src_b_ok;
  logic [DATA_W-1:0] imm1_val;
  logic [DATA_W-1:0] imm2_val;
  logic [DATA_W-1:0] mul_lo;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic              is_signed;
  logic [DATA_W-1:0] div_res;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign s_src_a  = s_tdata[13:10];
  assign s_src_b  = s_tdata[17:14];
  assign src_a_ok = 32'(s_src_a) < REG_COUNT;
  assign src_b_ok = 32'(s_src_b) < REG_COUNT;
  assign dest_ok  = 32'(dest) < REG_COUNT;

  assign imm1_val = DATA_W'(imm1) & IMM_MASK;
  assign imm2_val = DATA_W'(imm2) & IMM_MASK;

  // low half of the product is the same for signed and unsigned operands
  assign mul_lo   = opa * opb;

  assign is_signed = (cmd == CMD_DIVS) || (cmd == CMD_REMS);
  assign mag_a     = (is_signed && opa[DATA_W-1]) ? (DATA_W'(0) - opa) : opa;
  assign mag_b     = (is_signed && opb[DATA_W-1]) ? (DATA_W'(0) - opb) : opb;

  // launch the divider for every divide or remainder with a non-zero divisor
  always_comb begin
    div_req.dividend = mag_a;
    div_req.divisor  = mag_b;
    case (cmd)
      CMD_DIVU, CMD_DIVS, CMD_REMU, CMD_REMS:
        div_req.start = (state == ST_CALC) && (opb != '0);
      default:
        div_req.start = 1'b0;
    endcase
  end

  rfme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // restore signs: quotient negative when signs differ, remainder follows dividend
  always_comb begin
    case (cmd)
      CMD_DIVU: div_res = div_rsp.quotient;
      CMD_DIVS: div_res = (opa[DATA_W-1] ^ opb[DATA_W-1]) ?
                          (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;
      CMD_REMS: div_res = opa[DATA_W-1] ?
                          (DATA_W'(0) - div_rsp.remainder) : div_rsp.remainder;
      default:  div_res = div_rsp.remainder;
    endcase
  end

  assign wr_en = (state == ST_FINISH) && out_free && res_ok && dest_ok;

  // register file: two registered read ports, one write port
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a    <= regs[AW'(s_src_a)];
      rd_b    <= regs[AW'(s_src_b)];
      rd_a_ok <= src_a_ok && reg_valid[AW'(s_src_a)];
      rd_b_ok <= src_b_ok && reg_valid[AW'(s_src_b)];
    end
    if (wr_en) begin
      regs[AW'(dest)] <= res;
    end
  end

  // valid bits stand in for clearing the file at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (wr_en) begin
      reg_valid[AW'(dest)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drop the output transaction once taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd   <= s_tdata[3:0];
            mode  <= s_tdata[5:4];
            dest  <= s_tdata[9:6];
            imm1  <= s_tdata[33:18];
            imm2  <= s_tdata[49:34];
            state <= ST_OPER;
          end
        end
        ST_OPER: begin
          // pick operands; out-of-range or unwritten registers read as zero
          case (mode)
            MODE_REG_REG: begin
              opa <= rd_a_ok ? rd_a : '0;
              opb <= rd_b_ok ? rd_b : '0;
            end
            MODE_REG_IMM: begin
              opa <= rd_a_ok ? rd_a : '0;
              opb <= imm1_val;
            end
            MODE_IMM_REG: begin
              opa <= imm1_val;
              opb <= rd_a_ok ? rd_a : '0;
            end
            default: begin
              opa <= imm1_val;
              opb <= imm2_val;
            end
          endcase
          state <= ST_CALC;
        end
        ST_CALC: begin
          dz     <= 1'b0;
          res_ok <= 1'b1;
          state  <= ST_FINISH;
          case (cmd)
            CMD_ADD:  res <= opa + opb;
            CMD_SUB:  res <= opa - opb;
            CMD_MULU, CMD_MULS: res <= mul_lo;
            CMD_AND:  res <= opa & opb;
            CMD_OR:   res <= opa | opb;
            CMD_XOR:  res <= opa ^ opb;
            CMD_DIVU, CMD_DIVS: begin
              if (opb == '0) begin
                dz  <= 1'b1;
                res <= '1;
              end else begin
                state <= ST_DIV;
              end
            end
            CMD_REMU, CMD_REMS: begin
              if (opb == '0) begin
                dz  <= 1'b1;
                res <= opa;
              end else begin
                state <= ST_DIV;
              end
            end
            default: begin
              res_ok <= 1'b0;
              res    <= '0;
            end
          endcase
        end
        ST_DIV: begin
          // hold until the divider retires its last bit
          if (div_rsp.done) begin
            res   <= div_res;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // advance only when the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= {dz, res_ok && dest_ok};
            m_tdata  <= {4'd0,
                         (res_ok && dest_ok) ? res : '0,
                         (res_ok && dest_ok) ? dest : '0};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for register_file_math_execute.
// Drives decoded math instructions over the s_* stream, predicts each result
// against its own copy of the register file and checks the m_* stream.
`timescale 1ns / 100ps

module tb;
  import rfme_pkg::*;

  localparam int REG_COUNT   = 16;
  localparam int IMM_WIDTH   = 16;
  localparam int CYCLE_LIMIT = 600000;
  // Allow for the slowest instruction, a full divide, plus a margin.
  localparam int DRAIN_CYCLES = 50;
  localparam int PRINT_LIMIT  = 40;

  // Command codes with no operation behind them.
  localparam logic [3:0] CMD_SPARE_LO = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  // One decoded instruction, laid out as on s_tdata (command lowest).
  typedef struct packed {
    logic [15:0] imm_second;
    logic [15:0] imm_first;
    logic [3:0]  src_b;
    logic [3:0]  src_a;
    logic [3:0]  dest;
    logic [1:0]  mode;
    logic [3:0]  cmd;
  } math_instr_t;

  typedef struct packed {
    logic        wrote;
    logic        div_zero;
    logic [3:0]  index;
    logic [31:0] value;
  } math_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [3:0] command, [5:4] operand_mode, [9:6] dest_index, [13:10] src_a_index,
  // [17:14] src_b_index, [33:18] imm_first, [49:34] imm_second, rest zero
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [3:0] written_index, [35:4] written_value, rest zero
  logic [M_TDATA_W-1:0] m_tdata;
  // [0] wrote, [1] divide_by_zero
  logic [M_TUSER_W-1:0] m_tuser;

  // Instructions waiting to be driven, and results predicted but not yet seen.
  math_instr_t  instr_q[$];
  math_result_t result_q[$];

  // Shadow copy of the register file, updated as each instruction is taken.
  logic [31:0] shadow_regs [REG_COUNT] = '{default: '0};

  logic in_taken = 1'b0;
  int   tx_idle_pct = 10;
  int   rx_idle_pct = 10;
  int   cycle_count = 0;
  int   taken_count = 0;
  int   checked_count = 0;
  int   div_zero_count = 0;
  int   skip_count = 0;
  int   mismatch_count = 0;

  register_file_math_execute #(
    .REG_COUNT (REG_COUNT),
    .IMM_WIDTH (IMM_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Execute one instruction on the shadow register file and return the
  // result transaction it should produce.
  function automatic math_result_t execute_math(math_instr_t ins);
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  r;
    logic [31:0]  mag_a;
    logic [31:0]  mag_b;
    logic         neg_a;
    logic         neg_b;
    logic         known;
    logic         dz;
    math_result_t res;
    case (ins.mode)
      MODE_REG_REG: begin
        a = shadow_regs[ins.src_a];
        b = shadow_regs[ins.src_b];
      end
      MODE_REG_IMM: begin
        a = shadow_regs[ins.src_a];
        b = 32'(ins.imm_first);
      end
      MODE_IMM_REG: begin
        a = 32'(ins.imm_first);
        b = shadow_regs[ins.src_a];
      end
      default: begin
        a = 32'(ins.imm_first);
        b = 32'(ins.imm_second);
      end
    endcase
    // Signed divide works on magnitudes, then fixes the sign up.
    neg_a = a[31];
    neg_b = b[31];
    mag_a = neg_a ? -a : a;
    mag_b = neg_b ? -b : b;
    r     = '0;
    known = 1'b1;
    dz    = 1'b0;
    case (ins.cmd)
      CMD_ADD:  r = a + b;
      CMD_SUB:  r = a - b;
      CMD_MULU,
      CMD_MULS: r = a * b;
      CMD_DIVU: begin
        if (b == 0) begin
          dz = 1'b1;
          r  = '1;
        end else begin
          r = a / b;
        end
      end
      CMD_DIVS: begin
        if (b == 0) begin
          dz = 1'b1;
          r  = '1;
        end else begin
          r = mag_a / mag_b;
          if (neg_a ^ neg_b) r = -r;
        end
      end
      CMD_REMU: begin
        if (b == 0) begin
          dz = 1'b1;
          r  = a;
        end else begin
          r = a % b;
        end
      end
      CMD_REMS: begin
        if (b == 0) begin
          dz = 1'b1;
          r  = a;
        end else begin
          r = mag_a % mag_b;
          if (neg_a) r = -r;
        end
      end
      CMD_AND:  r = a & b;
      CMD_OR:   r = a | b;
      CMD_XOR:  r = a ^ b;
      default:  known = 1'b0;
    endcase
    res = '0;
    if (known && ins.dest < REG_COUNT) begin
      shadow_regs[ins.dest] = r;
      res.wrote = 1'b1;
      res.index = ins.dest;
      res.value = r;
    end
    res.div_zero = dz;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("tb: mismatch in %s at result %0d: got %h, want %h",
               what, checked_count, got, want);
  endtask

  task automatic push_instr(logic [3:0] cmd, logic [1:0] mode, logic [3:0] dest,
                            logic [3:0] src_a, logic [3:0] src_b,
                            logic [15:0] imm_first, logic [15:0] imm_second);
    math_instr_t ins;
    ins = '{imm_second: imm_second, imm_first: imm_first, src_b: src_b,
            src_a: src_a, dest: dest, mode: mode, cmd: cmd};
    instr_q.push_back(ins);
  endtask

  // Favour the edges of the immediate range, with plenty of zeros for the
  // zero-divisor paths.
  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(1, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int count);
    logic [3:0] cmd;
    for (int i = 0; i < count; i++) begin
      // Mostly real operations; now and then a code that writes nothing.
      if ($urandom_range(0, 99) < 8) begin
        cmd = ($urandom_range(0, 4) == 0) ? CMD_NONE
                                          : 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end else begin
        cmd = 4'($urandom_range(CMD_ADD, CMD_XOR));
      end
      push_instr(cmd, 2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom),
                 4'($urandom), pick_imm(), pick_imm());
    end
  endtask

  // Hold until every queued instruction has gone and every result is in.
  task automatic wait_drained();
    while (instr_q.size() != 0 || s_tvalid || result_q.size() != 0)
      @(negedge clk);
  endtask

  // Driver: present the next instruction on the falling edge once the slot
  // is free; hold the transaction until it is taken, never withdraw it.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (instr_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_tdata  <= S_TDATA_W'(instr_q.pop_front());
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, drawn afresh every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor: on each rising edge, predict from an accepted instruction and
  // check an accepted result against the oldest prediction.
  always @(posedge clk) begin
    math_instr_t  ins;
    math_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        ins = math_instr_t'(s_tdata[$bits(math_instr_t)-1:0]);
        result_q.push_back(execute_math(ins));
        taken_count++;
      end
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          flag_mismatch("unexpected result", m_tdata[35:4], '0);
        end else begin
          want = result_q.pop_front();
          if (m_tuser[0] !== want.wrote)
            flag_mismatch("wrote", 32'(m_tuser[0]), 32'(want.wrote));
          if (m_tuser[1] !== want.div_zero)
            flag_mismatch("divide_by_zero", 32'(m_tuser[1]), 32'(want.div_zero));
          if (m_tdata[3:0] !== want.index)
            flag_mismatch("written_index", 32'(m_tdata[3:0]), 32'(want.index));
          if (m_tdata[35:4] !== want.value)
            flag_mismatch("written_value", m_tdata[35:4], want.value);
          if (want.div_zero) div_zero_count++;
          if (!want.wrote) skip_count++;
        end
        checked_count++;
      end
    end
  end

  // Watchdog: stop a run that has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timed out after %0d cycles", cycle_count);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed part: build the awkward operands in registers first, then
    // drive the corner cases against them.
    push_instr(CMD_SUB,  MODE_IMM_IMM, 4'd1,  4'd0, 4'd0, 16'h0000, 16'h0001); // r1 = -1
    push_instr(CMD_MULU, MODE_IMM_IMM, 4'd2,  4'd0, 4'd0, 16'h8000, 16'h8000);
    push_instr(CMD_ADD,  MODE_REG_REG, 4'd3,  4'd2, 4'd2, 16'h0000, 16'h0000); // r3 = min
    // Signed minimum over -1 wraps, remainder zero.
    push_instr(CMD_DIVS, MODE_REG_REG, 4'd4,  4'd3, 4'd1, 16'h0000, 16'h0000);
    push_instr(CMD_REMS, MODE_REG_REG, 4'd5,  4'd3, 4'd1, 16'h0000, 16'h0000);
    // Truncation toward zero, remainder following the dividend's sign.
    push_instr(CMD_SUB,  MODE_IMM_IMM, 4'd7,  4'd0, 4'd0, 16'h0000, 16'h0007); // r7 = -7
    push_instr(CMD_DIVS, MODE_REG_IMM, 4'd8,  4'd7, 4'd0, 16'h0002, 16'h0000);
    push_instr(CMD_REMS, MODE_REG_IMM, 4'd9,  4'd7, 4'd0, 16'h0002, 16'h0000);
    push_instr(CMD_DIVS, MODE_IMM_REG, 4'd10, 4'd7, 4'd0, 16'hFFFF, 16'h0000);
    push_instr(CMD_REMS, MODE_IMM_REG, 4'd11, 4'd7, 4'd0, 16'hFFFF, 16'h0000);
    // Zero divisor on every divide and remainder flavour.
    push_instr(CMD_DIVU, MODE_REG_IMM, 4'd12, 4'd1, 4'd0, 16'h0000, 16'h0000);
    push_instr(CMD_DIVS, MODE_REG_REG, 4'd13, 4'd7, 4'd0, 16'h0000, 16'h0000);
    push_instr(CMD_REMU, MODE_IMM_IMM, 4'd14, 4'd0, 4'd0, 16'hFFFF, 16'h0000);
    push_instr(CMD_REMS, MODE_REG_REG, 4'd15, 4'd3, 4'd0, 16'h0000, 16'h0000);
    push_instr(CMD_DIVU, MODE_REG_REG, 4'd6,  4'd1, 4'd7, 16'h0000, 16'h0000);
    push_instr(CMD_REMU, MODE_REG_REG, 4'd6,  4'd1, 4'd3, 16'h0000, 16'h0000);
    push_instr(CMD_MULS, MODE_REG_REG, 4'd0,  4'd1, 4'd1, 16'h0000, 16'h0000);
    push_instr(CMD_MULU, MODE_REG_IMM, 4'd6,  4'd1, 4'd0, 16'hFFFF, 16'h0000);
    push_instr(CMD_MULS, MODE_REG_IMM, 4'd8,  4'd7, 4'd0, 16'h0003, 16'h0000);
    push_instr(CMD_AND,  MODE_REG_REG, 4'd9,  4'd1, 4'd3, 16'h0000, 16'h0000);
    push_instr(CMD_OR,   MODE_IMM_REG, 4'd10, 4'd3, 4'd0, 16'h5555, 16'h0000);
    push_instr(CMD_XOR,  MODE_REG_IMM, 4'd11, 4'd1, 4'd0, 16'hAAAA, 16'h0000);
    // Codes that write nothing, and the largest immediates summed.
    push_instr(CMD_NONE,     MODE_IMM_IMM, 4'd5,  4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
    push_instr(CMD_SPARE_LO, MODE_REG_REG, 4'd4,  4'd1, 4'd3, 16'h0000, 16'h0000);
    push_instr(CMD_SPARE_HI, MODE_IMM_IMM, 4'd15, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
    push_instr(CMD_ADD,      MODE_IMM_IMM, 4'd15, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Random traffic with light idling on both sides.
    queue_random(700);
    wait_drained();

    // A long stretch at full rate: no gaps from the sender, no stalls.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(400);
    wait_drained();

    tx_idle_pct = 10;
    rx_idle_pct = 10;
    queue_random(700);
    wait_drained();

    // Let any stray result surface before closing.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb: %0d instructions taken, %0d results checked in %0d cycles",
             taken_count, checked_count, cycle_count);
    $display("tb: %0d zero-divisor results, %0d with no write, %0d mismatches",
             div_zero_count, skip_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
